>>> rtl/core/smacc_pkg.sv
// ----------------------------------------------------------------------------
// smacc_pkg
// Shared sizes, codes and the command type of the skyline matrix accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
package smacc_pkg;

  localparam int MAX_DOF     = 1024;
  localparam int STORE_DEPTH = 16384;
  localparam int DOF_W       = $clog2(MAX_DOF);
  localparam int CNT_W       = DOF_W + 1;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int LIM_W       = STORE_AW + 1;
  localparam int TOTAL_W     = 20;
  localparam int VAL_W       = 64;

  localparam logic [2:0] ACT_TOUCH    = 3'd0;
  localparam logic [2:0] ACT_FINALIZE = 3'd1;
  localparam logic [2:0] ACT_ADD      = 3'd2;
  localparam logic [2:0] ACT_SET      = 3'd3;
  localparam logic [2:0] ACT_GET      = 3'd4;
  localparam logic [2:0] ACT_RESTART  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OUTSIDE  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [2:0]       op;
    logic [DOF_W-1:0] r;
    logic [DOF_W-1:0] c;
    logic [VAL_W-1:0] v;
    logic             col_ok;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/smacc_front.sv
// ----------------------------------------------------------------------------
// smacc_front
// Orders the DOF pair of an incoming item and checks its column against the
// matrix order.
// ----------------------------------------------------------------------------
`default_nettype none
module smacc_front (
  input  wire logic [2:0]                     action,
  input  wire logic [smacc_pkg::DOF_W-1:0]    row,
  input  wire logic [smacc_pkg::DOF_W-1:0]    col,
  input  wire logic [smacc_pkg::VAL_W-1:0]    value,
  input  wire logic [smacc_pkg::CNT_W-1:0]    order,
  output smacc_pkg::cmd_t                     cmd
);

  logic swap;

  always_comb begin
    swap       = row > col;
    cmd.op     = action;
    cmd.r      = swap ? col : row;
    cmd.c      = swap ? row : col;
    cmd.v      = value;
    cmd.col_ok = {1'b0, cmd.c} < order;
  end

endmodule
`default_nettype wire

>>> rtl/core/smacc_queue.sv
// ----------------------------------------------------------------------------
// smacc_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module smacc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire smacc_pkg::cmd_t push_cmd,
  input  wire logic            pop,
  output smacc_pkg::cmd_t      head,
  output logic                 full,
  output logic                 empty
);

  smacc_pkg::cmd_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_cmd;
  end

  assign head  = slot[rd_ptr];
  assign full  = count == 2'd2;
  assign empty = count == 2'd0;

endmodule
`default_nettype wire

>>> rtl/core/smacc_back.sv
// ----------------------------------------------------------------------------
// smacc_back
// Sequencer that owns the profile, offset and value memories and carries out
// one command at a time into the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module smacc_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [smacc_pkg::CNT_W-1:0]      order,
  input  wire smacc_pkg::cmd_t                  head,
  input  wire logic                             q_empty,
  output logic                                  pop,
  output logic                                  init_busy,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            status,
  output logic [smacc_pkg::VAL_W-1:0]           read_value,
  output logic [smacc_pkg::DOF_W-1:0]           bandwidth,
  output logic [smacc_pkg::TOTAL_W-1:0]         stored_count
);

  localparam int DW = smacc_pkg::DOF_W;
  localparam int CW = smacc_pkg::CNT_W;
  localparam int AW = smacc_pkg::STORE_AW;
  localparam int LW = smacc_pkg::LIM_W;
  localparam int TW = smacc_pkg::TOTAL_W;
  localparam int VW = smacc_pkg::VAL_W;
  localparam logic [CW-1:0] LAST_COL   = CW'(smacc_pkg::MAX_DOF - 1);
  localparam logic [TW-1:0] DEPTH_TOT  = TW'(smacc_pkg::STORE_DEPTH);
  localparam logic [LW-1:0] DEPTH_LIM  = LW'(smacc_pkg::STORE_DEPTH);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_TOUCH   = 4'd1;
  localparam logic [3:0] S_RESTART = 4'd2;
  localparam logic [3:0] S_FIN_RD  = 4'd3;
  localparam logic [3:0] S_FIN_ACC = 4'd4;
  localparam logic [3:0] S_CLEAR   = 4'd5;
  localparam logic [3:0] S_ACC_CHK = 4'd6;
  localparam logic [3:0] S_ACC_RD  = 4'd7;
  localparam logic [3:0] S_ACC_EXE = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [DW-1:0] top_mem   [smacc_pkg::MAX_DOF];
  logic [TW-1:0] off_mem   [smacc_pkg::MAX_DOF];
  logic [VW-1:0] store_mem [smacc_pkg::STORE_DEPTH];

  logic [3:0]    state;
  smacc_pkg::cmd_t cur;
  logic          layout_valid;
  logic          silent;
  logic [CW-1:0] idx;
  logic [LW-1:0] clr_idx;
  logic [TW-1:0] sum;
  logic [DW-1:0] maxh;
  logic [LW-1:0] clr_lim;
  logic [DW-1:0] max_height;
  logic [TW-1:0] entry_total;
  logic [LW-1:0] limit;
  logic [AW-1:0] acc_addr;
  logic [1:0]    res_status;
  logic [VW-1:0] res_value;

  logic [DW-1:0] top_raddr;
  logic [DW-1:0] top_rdata;
  logic [TW-1:0] off_rdata;
  logic [VW-1:0] st_rdata;
  logic          top_we;
  logic [DW-1:0] top_waddr;
  logic [DW-1:0] top_wdata;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [VW-1:0] st_wdata;

  logic          start;
  logic [DW-1:0] h;
  logic [TW-1:0] sum_next;
  logic [TW:0]   acc_a;
  logic [VW-1:0] add_sum;
  logic [VW-1:0] add_sat;

  assign start     = (state == S_IDLE) && !q_empty && !(out_valid && out_stall);
  assign pop       = start;
  assign init_busy = (state == S_RESTART) && silent;

  always_comb begin
    h        = idx[DW-1:0] - top_rdata;
    sum_next = sum + TW'(h) + TW'(1);
    acc_a    = {1'b0, off_rdata} + (TW+1)'(cur.r - top_rdata);
    add_sum  = st_rdata + cur.v;
    add_sat  = add_sum;
    // Saturate when both operands share a sign that the sum lost.
    if (st_rdata[VW-1] == cur.v[VW-1] && add_sum[VW-1] != st_rdata[VW-1]) begin
      add_sat = st_rdata[VW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end
  end

  always_comb begin
    top_raddr = (state == S_IDLE) ? head.c : idx[DW-1:0];
    top_we    = 1'b0;
    top_waddr = idx[DW-1:0];
    top_wdata = idx[DW-1:0];
    st_we     = 1'b0;
    st_waddr  = acc_addr;
    st_wdata  = '0;
    case (state)
      S_RESTART: top_we = 1'b1;
      S_TOUCH: begin
        top_we    = cur.col_ok && (cur.r < top_rdata);
        top_waddr = cur.c;
        top_wdata = cur.r;
      end
      S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_idx[AW-1:0];
      end
      S_ACC_EXE: begin
        st_we    = cur.op != smacc_pkg::ACT_GET;
        st_wdata = (cur.op == smacc_pkg::ACT_ADD) ? add_sat : cur.v;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    top_rdata <= top_mem[top_raddr];
    off_rdata <= off_mem[top_raddr];
    st_rdata  <= store_mem[acc_addr];
    if (top_we) top_mem[top_waddr] <= top_wdata;
    if (st_we) store_mem[st_waddr] <= st_wdata;
    if (state == S_FIN_ACC) off_mem[idx[DW-1:0]] <= sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RESTART;
      silent       <= 1'b1;
      idx          <= '0;
      layout_valid <= 1'b0;
      max_height   <= '0;
      entry_total  <= '0;
      limit        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur        <= head;
            idx        <= '0;
            res_status <= smacc_pkg::ST_OK;
            res_value  <= '0;
            silent     <= 1'b0;
            case (head.op)
              smacc_pkg::ACT_TOUCH: begin
                layout_valid <= 1'b0;
                state        <= S_TOUCH;
              end
              smacc_pkg::ACT_FINALIZE: begin
                sum   <= '0;
                maxh  <= '0;
                state <= S_FIN_RD;
              end
              smacc_pkg::ACT_ADD, smacc_pkg::ACT_SET, smacc_pkg::ACT_GET:
                state <= S_ACC_CHK;
              smacc_pkg::ACT_RESTART: begin
                layout_valid <= 1'b0;
                state        <= S_RESTART;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_TOUCH: state <= S_DONE;
        S_RESTART: begin
          idx <= idx + CW'(1);
          if (idx == LAST_COL) state <= silent ? S_IDLE : S_DONE;
        end
        S_FIN_RD: state <= S_FIN_ACC;
        S_FIN_ACC: begin
          sum <= sum_next;
          if (h > maxh) maxh <= h;
          if (idx == order - CW'(1)) begin
            idx     <= '0;
            clr_idx <= '0;
            clr_lim <= (sum_next > DEPTH_TOT) ? DEPTH_LIM : LW'(sum_next);
            state   <= S_CLEAR;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_FIN_RD;
          end
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + LW'(1);
          if (clr_idx + LW'(1) == clr_lim) begin
            max_height   <= maxh;
            entry_total  <= sum;
            limit        <= clr_lim;
            layout_valid <= 1'b1;
            if (sum > DEPTH_TOT) res_status <= smacc_pkg::ST_OVERFLOW;
            state <= S_DONE;
          end
        end
        S_ACC_CHK: begin
          if (!cur.col_ok) begin
            res_status <= smacc_pkg::ST_OVERFLOW;
            state      <= S_DONE;
          end else if (!layout_valid || cur.r < top_rdata) begin
            res_status <= smacc_pkg::ST_OUTSIDE;
            state      <= S_DONE;
          end else if (acc_a >= (TW+1)'(limit)) begin
            res_status <= smacc_pkg::ST_OVERFLOW;
            state      <= S_DONE;
          end else begin
            acc_addr <= acc_a[AW-1:0];
            state    <= S_ACC_RD;
          end
        end
        S_ACC_RD: state <= S_ACC_EXE;
        S_ACC_EXE: begin
          if (cur.op == smacc_pkg::ACT_GET) res_value <= st_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          out_valid    <= 1'b1;
          status       <= res_status;
          read_value   <= res_value;
          bandwidth    <= max_height;
          stored_count <= entry_total;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/skyline_matrix_accumulator.sv
// ----------------------------------------------------------------------------
// skyline_matrix_accumulator
// Skyline profile store for a symmetric matrix with Q32.32 entries.
//
// Items arrive on the input channel (valid/stall) and each gives exactly one
// result on the output channel (valid/stall), in order. The front orders the
// DOF pair and checks the column, a two-entry queue holds commands, and the
// back sequencer runs them against the profile, offset and value memories.
// Restart resets one column's top row a cycle; finalize walks each column of
// the order and then clears each stored entry (at most STORE_DEPTH). The
// memories' single ports and the read-modify-write of add shape these
// sequences; items run one at a time.
// After reset a clearing pass restores each column's top row;
// input transfers are stalled meanwhile, configuration writes are taken.
// The result register holds while the receiver stalls, and the back starts
// no new command until it is free; the queue keeps taking items until full.
// The matrix order is written on its own valid/ready channel (cfg_data); the
// user writes it only while the block idles, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none
module skyline_matrix_accumulator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [10:0]                      cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [2:0]                       action,
  input  wire logic [smacc_pkg::DOF_W-1:0]      row,
  input  wire logic [smacc_pkg::DOF_W-1:0]      col,
  input  wire logic [smacc_pkg::VAL_W-1:0]      value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            status,
  output logic [smacc_pkg::VAL_W-1:0]           read_value,
  output logic [smacc_pkg::DOF_W-1:0]           bandwidth,
  output logic [smacc_pkg::TOTAL_W-1:0]         stored_count
);

  localparam int CW = smacc_pkg::CNT_W;
  localparam logic [10:0] MAX_N = 11'(smacc_pkg::MAX_DOF);

  logic [10:0]     dof_reg;
  logic [CW-1:0]   order;
  smacc_pkg::cmd_t cmd;
  smacc_pkg::cmd_t head;
  logic            q_full;
  logic            q_empty;
  logic            pop;
  logic            init_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dof_reg <= MAX_N;
    end else if (cfg_valid) begin
      dof_reg <= cfg_data;
    end
  end

  // An order of zero acts as one, and anything above the column count clamps.
  always_comb begin
    if (dof_reg == 11'd0) order = CW'(1);
    else if (dof_reg > MAX_N) order = CW'(smacc_pkg::MAX_DOF);
    else order = CW'(dof_reg);
  end

  assign in_stall = q_full || init_busy;

  smacc_front u_front (
    .action (action),
    .row    (row),
    .col    (col),
    .value  (value),
    .order  (order),
    .cmd    (cmd)
  );

  smacc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_valid && !in_stall),
    .push_cmd (cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  smacc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .order        (order),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .init_busy    (init_busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .read_value   (read_value),
    .bandwidth    (bandwidth),
    .stored_count (stored_count)
  );

endmodule
`default_nettype wire
